@@ design/astg_pkg.sv @@
// ============================================================================
// astg_pkg: shared types and constants of the additive sine tone generator
// Holds the config record, divider request/response, sequencer states and
// fixed-point constants of the sine evaluation.
// ============================================================================
package astg_pkg;

    localparam int TONE_REGS     = 4;
    localparam int NUM_TONES_DEF = 4;
    localparam int IDX_W         = 17;
    localparam int PER_W         = 10;
    localparam int DIV_W         = 41;
    localparam int STEP_W        = 6;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [16:0] INDEX_MAX   = 17'h1FFFF;
    localparam logic [14:0] AMPLITUDE   = 15'd20000;
    localparam logic [15:0] MAG_MAX     = 16'h8000;

    typedef enum logic [2:0] {
        CFG_TONE_COUNT,
        CFG_NOTE_SAMPLES,
        CFG_SILENT_NOTE,
        CFG_PERIOD_A,
        CFG_PERIOD_B,
        CFG_PERIOD_C,
        CFG_PERIOD_D
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]                           tone_count;
        logic [IDX_W-1:0]                     note_samples;
        logic                                 silent_note;
        logic [TONE_REGS-1:0][PER_W-1:0]      period;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [PER_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [PER_W-1:0]  rem;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TONE,
        S_L_MODI,
        S_W_MODI,
        S_L_NOTE,
        S_W_NOTE,
        S_L_QUAD,
        S_W_QUAD,
        S_XMUL,
        S_L_ANGLE,
        S_W_ANGLE,
        S_SQR,
        S_TMUL,
        S_L_TAY,
        S_W_TAY,
        S_SIN,
        S_MAG,
        S_AMP,
        S_L_SCALE,
        S_W_SCALE,
        S_NEXT,
        S_DONE
    } t_state;

    // Taylor series divisors, innermost term first
    function automatic logic [PER_W-1:0] tay_div(input logic [2:0] j);
        logic [PER_W-1:0] d;
        unique case (j)
            3'd0:    d = 10'd156;
            3'd1:    d = 10'd110;
            3'd2:    d = 10'd72;
            3'd3:    d = 10'd42;
            3'd4:    d = 10'd20;
            default: d = 10'd6;
        endcase
        return d;
    endfunction

endpackage

@@ design/astg_div.sv @@
// ============================================================================
// astg_div: bit-serial restoring divider
// Left-aligned dividend, one quotient bit per cycle over a request's steps.
// ============================================================================
module astg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  astg_pkg::t_div_req i_req,
    output astg_pkg::t_div_rsp o_rsp
);
    import astg_pkg::*;

    logic [STEP_W-1:0] r_cnt;
    logic              r_done;
    logic [DIV_W-1:0]  r_q;
    logic [PER_W-1:0]  r_rem;
    logic [PER_W-1:0]  r_d;

    logic [PER_W:0]    rs;
    logic [PER_W:0]    diff;
    logic              ge;

    assign rs   = {r_rem, r_q[DIV_W-1]};
    assign diff = rs - {1'b0, r_d};
    assign ge   = (rs >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_cnt == '0) begin
                if (i_req.start) begin
                    r_cnt <= i_req.steps;
                end
            end else begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt == '0) begin
            if (i_req.start) begin
                r_q   <= i_req.dividend;
                r_rem <= '0;
                r_d   <= i_req.divisor;
            end
        end else begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? diff[PER_W-1:0] : rs[PER_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

@@ design/astg_core.sv @@
// ============================================================================
// astg_core: per-sample sequencer and sine datapath
// Walks the tones, runs all divisions on the shared serial divider and
// accumulates the mixed sample.
// ============================================================================
module astg_core #(
    parameter int NUM_TONES = astg_pkg::NUM_TONES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  astg_pkg::t_cfg           i_cfg,
    input  logic                     i_start,
    input  logic                     i_restart,
    output logic                     o_idle,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output logic [15:0]              o_sample,
    output logic                     o_last
);
    import astg_pkg::*;

    localparam int LIMIT_I = (NUM_TONES < TONE_REGS) ? NUM_TONES : TONE_REGS;
    localparam logic [2:0] LIMIT = 3'(LIMIT_I);

    t_state r_state, n_state;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [1:0]        r_t;
    logic [2:0]        r_j;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_qi;
    logic [PER_W-1:0]  r_pos;
    logic [PER_W-1:0]  r_r;
    logic              r_neg;
    logic [30:0]       r_x;
    logic [31:0]       r_x2;
    logic [30:0]       r_tay;
    logic [DIV_W-1:0]  r_acc;
    logic [15:0]       r_mag;
    logic [16:0]       r_sum;

    logic [2:0]        cnt_eff;
    logic [PER_W-1:0]  per;
    logic              in_note;
    logic              active;
    logic [16:0]       mag_rnd;
    logic [61:0]       sq;
    logic [62:0]       tp;
    logic [61:0]       sp;
    logic [30:0]       ap;

    astg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (i_cfg.tone_count == 3'd0) begin
            cnt_eff = 3'd1;
        end else if (i_cfg.tone_count > LIMIT) begin
            cnt_eff = LIMIT;
        end else begin
            cnt_eff = i_cfg.tone_count;
        end
    end

    assign per     = i_cfg.period[r_t];
    assign in_note = (r_i < i_cfg.note_samples);
    assign active  = ({1'b0, r_t} < cnt_eff) && (per != '0) && in_note && !i_cfg.silent_note;

    assign sq      = 62'(r_x) * 62'(r_x);
    assign tp      = 63'(r_x2) * 63'(r_tay);
    assign sp      = 62'(r_x) * 62'(r_tay);
    assign ap      = 31'(r_mag) * 31'(AMPLITUDE);
    assign mag_rnd = r_acc[31:15] + 17'(r_acc[14]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_start) n_state = S_TONE;
            S_TONE:    n_state = active ? S_L_MODI : S_NEXT;
            S_L_MODI:  n_state = S_W_MODI;
            S_W_MODI:  if (div_rsp.done) n_state = S_L_NOTE;
            S_L_NOTE:  n_state = S_W_NOTE;
            S_W_NOTE: begin
                if (div_rsp.done) begin
                    n_state = (r_qi < div_rsp.quot[IDX_W-1:0]) ? S_L_QUAD : S_NEXT;
                end
            end
            S_L_QUAD:  n_state = S_W_QUAD;
            S_W_QUAD:  if (div_rsp.done) n_state = S_XMUL;
            S_XMUL:    n_state = S_L_ANGLE;
            S_L_ANGLE: n_state = S_W_ANGLE;
            S_W_ANGLE: if (div_rsp.done) n_state = S_SQR;
            S_SQR:     n_state = S_TMUL;
            S_TMUL:    n_state = S_L_TAY;
            S_L_TAY:   n_state = S_W_TAY;
            S_W_TAY: begin
                if (div_rsp.done) begin
                    n_state = (r_j == 3'd5) ? S_SIN : S_TMUL;
                end
            end
            S_SIN:     n_state = S_MAG;
            S_MAG:     n_state = S_AMP;
            S_AMP:     n_state = S_L_SCALE;
            S_L_SCALE: n_state = S_W_SCALE;
            S_W_SCALE: if (div_rsp.done) n_state = S_NEXT;
            S_NEXT:    n_state = (r_t == 2'(TONE_REGS - 1)) ? S_DONE : S_TONE;
            S_DONE:    if (i_res_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        div_req       = '0;
        div_req.divisor = per;
        o_idle        = (r_state == S_IDLE);
        o_res_valid   = (r_state == S_DONE);
        unique case (r_state)
            S_L_MODI: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(IDX_W);
                div_req.dividend = {r_i, 24'b0};
            end
            S_L_NOTE: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(IDX_W);
                div_req.dividend = {i_cfg.note_samples, 24'b0};
            end
            S_L_QUAD: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(12);
                div_req.dividend = {r_pos, 2'b00, 29'b0};
            end
            S_L_ANGLE: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(DIV_W);
                div_req.dividend = r_acc;
            end
            S_L_TAY: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(32);
                div_req.dividend = {r_acc[31:0], 9'b0};
                div_req.divisor  = tay_div(r_j);
            end
            S_L_SCALE: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(15);
                div_req.dividend = {r_acc[14:0], 26'b0};
                div_req.divisor  = {7'b0, cnt_eff};
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && i_res_ready) begin
                r_idx <= (r_i < INDEX_MAX) ? r_i + 1'b1 : r_i;
            end else if (r_state == S_IDLE && i_start && i_restart) begin
                r_idx <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_i   <= i_restart ? '0 : r_idx;
                    r_t   <= '0;
                    r_sum <= '0;
                end
            end
            S_W_MODI: begin
                if (div_rsp.done) begin
                    r_qi  <= div_rsp.quot[IDX_W-1:0];
                    r_pos <= div_rsp.rem;
                end
            end
            S_W_QUAD: begin
                if (div_rsp.done) begin
                    r_neg <= div_rsp.quot[1];
                    r_r   <= div_rsp.quot[0] ? per - div_rsp.rem : div_rsp.rem;
                end
            end
            S_XMUL:    r_acc <= DIV_W'(HALF_PI_Q30) * DIV_W'(r_r);
            S_W_ANGLE: if (div_rsp.done) r_x <= div_rsp.quot[30:0];
            S_SQR: begin
                r_x2  <= sq[61:30];
                r_tay <= Q30_ONE;
                r_j   <= '0;
            end
            S_TMUL:    r_acc <= {9'b0, tp[61:30]};
            S_W_TAY: begin
                if (div_rsp.done) begin
                    r_tay <= Q30_ONE - div_rsp.quot[30:0];
                    r_j   <= r_j + 1'b1;
                end
            end
            S_SIN:     r_acc <= {10'b0, sp[60:30]};
            S_MAG:     r_mag <= (mag_rnd > {1'b0, MAG_MAX}) ? MAG_MAX : mag_rnd[15:0];
            S_AMP:     r_acc <= {26'b0, ap[29:15]};
            S_W_SCALE: begin
                if (div_rsp.done) begin
                    r_sum <= r_neg ? r_sum - {2'b0, div_rsp.quot[14:0]}
                                   : r_sum + {2'b0, div_rsp.quot[14:0]};
                end
            end
            S_NEXT:    r_t <= r_t + 1'b1;
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_sample = r_sum[15:0];
    assign o_last   = in_note && ({1'b0, r_i} + 18'd1 == {1'b0, i_cfg.note_samples});

endmodule

@@ design/additive_sine_tone_generator.sv @@
// ============================================================================
// additive_sine_tone_generator: additive sine synthesizer, one sample a request
// Config registers, input/output stream handshakes and the result register.
// ============================================================================
//  channel   | direction | payload
//  s_axis    | in        | tdata[0] restart
//  m_axis    | out       | tdata[15:0] sample, tlast last frame of note
//  cfg       | in        | i_cfg_index register, i_cfg_data value
//
//  Request spacing depends on the tones: an active tone adds its two index
//  divisions, a sounding tone its quadrant, angle, Taylor and scale divisions
//  as well; the shared bit-serial divider sets this. Reset is synchronous and
//  active low, no clearing pass. The result register frees the core: a new
//  request is taken while a result waits, and the core stalls only when a
//  second result is ready.
// ============================================================================
module additive_sine_tone_generator #(
    parameter int NUM_TONES = astg_pkg::NUM_TONES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import astg_pkg::*;

    t_cfg        r_cfg;
    logic        core_idle;
    logic        core_valid;
    logic        core_ready;
    logic [15:0] core_sample;
    logic        core_last;
    logic        r_out_valid;
    logic [15:0] r_out_sample;
    logic        r_out_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tone_count   <= 3'd1;
            r_cfg.note_samples <= '0;
            r_cfg.silent_note  <= 1'b0;
            for (int k = 0; k < TONE_REGS; k++) begin
                r_cfg.period[k] <= PER_W'(1);
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TONE_COUNT:   r_cfg.tone_count   <= i_cfg_data[2:0];
                CFG_NOTE_SAMPLES: r_cfg.note_samples <= i_cfg_data;
                CFG_SILENT_NOTE:  r_cfg.silent_note  <= i_cfg_data[0];
                CFG_PERIOD_A:     r_cfg.period[0]    <= i_cfg_data[PER_W-1:0];
                CFG_PERIOD_B:     r_cfg.period[1]    <= i_cfg_data[PER_W-1:0];
                CFG_PERIOD_C:     r_cfg.period[2]    <= i_cfg_data[PER_W-1:0];
                CFG_PERIOD_D:     r_cfg.period[3]    <= i_cfg_data[PER_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign s_axis_tready = core_idle;
    assign core_ready    = !r_out_valid || m_axis_tready;

    astg_core #(
        .NUM_TONES (NUM_TONES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (s_axis_tvalid && core_idle),
        .i_restart   (s_axis_tdata[0]),
        .o_idle      (core_idle),
        .o_res_valid (core_valid),
        .i_res_ready (core_ready),
        .o_sample    (core_sample),
        .o_last      (core_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_ready) begin
            r_out_valid <= core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_ready && core_valid) begin
            r_out_sample <= core_sample;
            r_out_last   <= core_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sample;
    assign m_axis_tlast  = r_out_last;

endmodule
